// ===== src/vtu_pkg.sv =====
`timescale 1ns / 1ps

package vtu_pkg;

  // Register file layout
  localparam int unsigned NUM_MROWS = 4;
  localparam int unsigned NUM_NROWS = 3;
  localparam int unsigned CFG_AW    = 6;

  typedef enum logic [2:0] {
    REG_MROW0 = 3'd0,
    REG_MROW1 = 3'd1,
    REG_MROW2 = 3'd2,
    REG_MROW3 = 3'd3,
    REG_NROW0 = 3'd4,
    REG_NROW1 = 3'd5,
    REG_NROW2 = 3'd6
  } reg_idx_e;

  // Identity matrices after reset
  localparam logic [63:0] MROW0_RST = 64'h0000_0000_0000_0100;
  localparam logic [63:0] MROW1_RST = 64'h0000_0000_0100_0000;
  localparam logic [63:0] MROW2_RST = 64'h0000_0100_0000_0000;
  localparam logic [63:0] MROW3_RST = 64'h0100_0000_0000_0000;
  localparam logic [47:0] NROW0_RST = 48'h0000_0000_1000;
  localparam logic [47:0] NROW1_RST = 48'h0000_1000_0000;
  localparam logic [47:0] NROW2_RST = 48'h1000_0000_0000;

  typedef struct packed {
    logic [NUM_MROWS-1:0][63:0] mrow;
    logic [NUM_NROWS-1:0][47:0] nrow;
  } vtu_cfg_t;

  // Arithmetic unit sizes
  localparam int unsigned SQRT_RW  = 32;
  localparam int unsigned SQRT_LAT = SQRT_RW;
  localparam int unsigned PDIV_DW  = 66;
  localparam int unsigned PDIV_VW  = 50;
  localparam int unsigned PDIV_QW  = 33;
  localparam int unsigned PDIV_LAT = PDIV_QW + 1;
  localparam int unsigned NDIV_DW  = 46;
  localparam int unsigned NDIV_VW  = 32;
  localparam int unsigned NDIV_QW  = 15;
  localparam int unsigned NDIV_LAT = NDIV_QW + 1;

  // Stage numbers (stage 1 is the first register after the input)
  localparam int unsigned FLAG_STG    = 3;
  localparam int unsigned TMS_STG     = 5;
  localparam int unsigned SUMSQ_STG   = 7;
  localparam int unsigned LEN_STG     = SUMSQ_STG + SQRT_LAT;
  localparam int unsigned NDIV_IN_STG = LEN_STG + 1;
  localparam int unsigned NQ_STG      = NDIV_IN_STG + NDIV_LAT;
  localparam int unsigned PIPE_DEPTH  = NQ_STG + 1;
  localparam int unsigned PQ_STG      = FLAG_STG + PDIV_LAT;
  localparam int unsigned PENC_STG    = PQ_STG + 1;
  localparam int unsigned PENC_DLY    = NQ_STG - PENC_STG;
  localparam int unsigned TM_DLY      = LEN_STG - TMS_STG;
  localparam int unsigned NFLAG_DLY   = NQ_STG - FLAG_STG;
  localparam int unsigned PFLAG_DLY   = PQ_STG - FLAG_STG;

  typedef struct packed {
    logic [2:0] qz;
    logic [2:0] qneg;
    logic [2:0] neg;
    logic       wz;
  } pos_flag_t;

  typedef struct packed {
    logic [2:0] tneg;
    logic       nz;
  } nrm_flag_t;

  typedef struct packed {
    logic             wz;
    logic [2:0][31:0] val;
  } pos_res_t;

  // Position of the leading one (0 when zero)
  function automatic logic [4:0] msb_pos(input logic [30:0] v);
    logic [4:0] pos;
    pos = '0;
    for (int i = 0; i < 31; i++) begin
      if (v[i]) pos = 5'(i);
    end
    return pos;
  endfunction

  // Encode a quotient magnitude as saturated Q16.16
  function automatic logic [31:0] enc_pos(input logic wz, input logic qz,
                                          input logic qneg, input logic neg,
                                          input logic ovf,
                                          input logic [PDIV_QW-1:0] q);
    logic [31:0] r;
    if (wz) begin
      if (qz) r = '0;
      else if (qneg) r = 32'h8000_0000;
      else r = 32'h7FFF_FFFF;
    end else if (neg) begin
      if (ovf || q > 33'h0_8000_0000) r = 32'h8000_0000;
      else r = 32'(33'd0 - q);
    end else begin
      if (ovf || q > 33'h0_7FFF_FFFF) r = 32'h7FFF_FFFF;
      else r = q[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/vtu_regs.sv =====
`timescale 1ns / 1ps

module vtu_regs import vtu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output vtu_cfg_t          cfg_o
);

  vtu_cfg_t cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[CFG_AW-1:3]);
  assign wr_en  = psel & penable & pwrite;

  // Decode the write request
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MROW0: cfg_d.mrow[0] = pwdata;
        REG_MROW1: cfg_d.mrow[1] = pwdata;
        REG_MROW2: cfg_d.mrow[2] = pwdata;
        REG_MROW3: cfg_d.mrow[3] = pwdata;
        REG_NROW0: cfg_d.nrow[0] = pwdata[47:0];
        REG_NROW1: cfg_d.nrow[1] = pwdata[47:0];
        REG_NROW2: cfg_d.nrow[2] = pwdata[47:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mrow[0] <= MROW0_RST;
      cfg_q.mrow[1] <= MROW1_RST;
      cfg_q.mrow[2] <= MROW2_RST;
      cfg_q.mrow[3] <= MROW3_RST;
      cfg_q.nrow[0] <= NROW0_RST;
      cfg_q.nrow[1] <= NROW1_RST;
      cfg_q.nrow[2] <= NROW2_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_MROW0: prdata = cfg_q.mrow[0];
      REG_MROW1: prdata = cfg_q.mrow[1];
      REG_MROW2: prdata = cfg_q.mrow[2];
      REG_MROW3: prdata = cfg_q.mrow[3];
      REG_NROW0: prdata = 64'(cfg_q.nrow[0]);
      REG_NROW1: prdata = 64'(cfg_q.nrow[1]);
      REG_NROW2: prdata = 64'(cfg_q.nrow[2]);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/vtu_dly.sv =====
`timescale 1ns / 1ps

module vtu_dly import vtu_pkg::*; #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [N];

  // Shift the payload along with the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int k = 1; k < N; k++) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  assign q_o = pipe_q[N-1];

endmodule

// ===== src/vtu_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
// ovf_o marks a quotient that does not fit in QW bits.
module vtu_div import vtu_pkg::*; #(
  parameter int unsigned DW = NDIV_DW,
  parameter int unsigned VW = NDIV_VW,
  parameter int unsigned QW = NDIV_QW
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] dvd_i,
  input  logic [VW-1:0] dvs_i,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o
);

  localparam int unsigned HW = DW - QW;
  localparam int unsigned CW = (HW > VW) ? HW : VW;

  logic [VW-1:0] rem_q [QW+1];
  logic [VW-1:0] dvs_q [QW+1];
  logic [QW-1:0] lo_q  [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          ovf_q [QW+1];

  logic [VW:0]   trial [QW+1];
  logic [VW:0]   diff  [QW+1];
  logic          ge    [QW+1];

  // Trial subtract per stage
  always_comb begin
    trial[0] = '0;
    diff[0]  = '0;
    ge[0]    = 1'b0;
    for (int k = 1; k <= QW; k++) begin
      trial[k] = {rem_q[k-1], lo_q[k-1][QW-1]};
      diff[k]  = trial[k] - {1'b0, dvs_q[k-1]};
      ge[k]    = (trial[k] >= {1'b0, dvs_q[k-1]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= VW'(dvd_i[DW-1:QW]);
      ovf_q[0] <= (CW'(dvd_i[DW-1:QW]) >= CW'(dvs_i));
      dvs_q[0] <= dvs_i;
      lo_q[0]  <= dvd_i[QW-1:0];
      quo_q[0] <= '0;
      for (int k = 1; k <= QW; k++) begin
        rem_q[k] <= ge[k] ? diff[k][VW-1:0] : trial[k][VW-1:0];
        dvs_q[k] <= dvs_q[k-1];
        lo_q[k]  <= lo_q[k-1] << 1;
        quo_q[k] <= {quo_q[k-1][QW-2:0], ge[k]};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

// ===== src/vtu_sqrt.sv =====
`timescale 1ns / 1ps

// Pipelined integer square root, one root bit per stage.
module vtu_sqrt import vtu_pkg::*; #(
  parameter int unsigned RW = SQRT_RW
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*RW-1:0] s_i,
  output logic [RW-1:0]   root_o
);

  logic [2*RW-1:0] s_q    [RW];
  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];

  logic [RW+1:0]   cur    [RW];
  logic [RW+1:0]   trial  [RW];
  logic            ge     [RW];

  // Bring down two bits and try the next root bit
  always_comb begin
    cur[0]   = {RW'(0), s_i[2*RW-1 -: 2]};
    trial[0] = (RW+2)'(1);
    ge[0]    = (cur[0] >= trial[0]);
    for (int k = 1; k < RW; k++) begin
      cur[k]   = {rem_q[k-1][RW-1:0], s_q[k-1][2*RW-1 -: 2]};
      trial[k] = {root_q[k-1], 2'b01};
      ge[k]    = (cur[k] >= trial[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0]    <= s_i << 2;
      rem_q[0]  <= ge[0] ? cur[0] - trial[0] : cur[0];
      root_q[0] <= RW'(ge[0]);
      for (int k = 1; k < RW; k++) begin
        s_q[k]    <= s_q[k-1] << 2;
        rem_q[k]  <= ge[k] ? cur[k] - trial[k] : cur[k];
        root_q[k] <= {root_q[k-1][RW-2:0], ge[k]};
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

// ===== src/vertex_transform_unit.sv =====
`timescale 1ns / 1ps

// Vertex transform unit: takes one vertex per clock while the output is not
// stalled and returns it with the position multiplied by the 4x4 matrix and
// divided by w (Q16.16, saturated) and the normal multiplied by the 3x3 normal
// matrix and scaled to unit length (Q1.14). Throughput is one vertex per cycle
// when the output is not held; the latency is set by the 32-stage square root
// and the 16-stage normal divide that follow seven stages of multiply, sum and
// normalize. A stall on the output freezes the whole pipeline. Matrices are
// loaded over the APB port at byte address 8*i and reset to identity.
module vertex_transform_unit import vtu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  // Vertex in
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // pos_x, pos_y, pos_z (32 each), norm_x, norm_y, norm_z (16 each)
  input  logic [143:0]      s_axis_tdata,
  // Vertex out
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // out_x, out_y, out_z (32 each), out_nx, out_ny, out_nz (16 each)
  output logic [143:0]      m_axis_tdata,
  // w_zero, normal_zero
  output logic [1:0]        m_axis_tuser
);

  vtu_cfg_t cfg;
  logic     en;
  logic [PIPE_DEPTH-1:0] vld_q;

  vtu_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance everything unless the output is held
  assign en            = !vld_q[PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  // Unpack operands
  logic signed [31:0] pin [3];
  logic signed [15:0] nin [3];
  logic signed [15:0] mel [4][4];
  logic signed [15:0] nel [3][3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pin[j] = $signed(s_axis_tdata[32*j +: 32]);
      nin[j] = $signed(s_axis_tdata[96+16*j +: 16]);
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        mel[i][j] = $signed(cfg.mrow[i][16*j +: 16]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        nel[i][j] = $signed(cfg.nrow[i][16*j +: 16]);
      end
    end
  end

  // Stage 1: products
  logic signed [47:0] pprod_q [4][3];
  logic signed [15:0] pcol_q  [4];
  logic signed [31:0] nprod_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        pcol_q[i] <= mel[i][3];
        for (int j = 0; j < 3; j++) begin
          pprod_q[i][j] <= 48'(mel[i][j]) * 48'(pin[j]);
        end
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          nprod_q[i][j] <= 32'(nel[i][j]) * 32'(nin[j]);
        end
      end
    end
  end

  // Stage 2: row sums, the constant 1.0 term added as a shift
  logic signed [49:0] psum_q [4];
  logic signed [33:0] nsum_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        psum_q[i] <= 50'(pprod_q[i][0]) + 50'(pprod_q[i][1]) + 50'(pprod_q[i][2])
                   + (50'(pcol_q[i]) <<< 16);
      end
      for (int i = 0; i < 3; i++) begin
        nsum_q[i] <= 34'(nprod_q[i][0]) + 34'(nprod_q[i][1]) + 34'(nprod_q[i][2]);
      end
    end
  end

  // Stage 3: magnitudes and signs
  logic [49:0] pmag_q [4];
  logic [31:0] tm_q   [3];
  pos_flag_t   pflag_q;
  nrm_flag_t   nflag_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        pmag_q[i] <= psum_q[i][49] ? 50'(-psum_q[i]) : 50'(psum_q[i]);
      end
      for (int i = 0; i < 3; i++) begin
        pflag_q.qz[i]   <= (psum_q[i] == '0);
        pflag_q.qneg[i] <= psum_q[i][49];
        pflag_q.neg[i]  <= psum_q[i][49] ^ psum_q[3][49];
        tm_q[i]         <= nsum_q[i][33] ? 32'(-nsum_q[i]) : 32'(nsum_q[i]);
        nflag_q.tneg[i] <= nsum_q[i][33];
      end
      pflag_q.wz <= (psum_q[3] == '0);
      nflag_q.nz <= (nsum_q[0] == '0) && (nsum_q[1] == '0) && (nsum_q[2] == '0);
    end
  end

  // Stage 4: common shift from the leading one of the three normal magnitudes
  logic [31:0] tm4_q [3];
  logic        rsh_q;
  logic [4:0]  lsh_q;
  logic [31:0] tm_or;

  assign tm_or = tm_q[0] | tm_q[1] | tm_q[2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) tm4_q[i] <= tm_q[i];
      rsh_q <= tm_or[31];
      lsh_q <= 5'd30 - msb_pos(tm_or[30:0]);
    end
  end

  // Stage 5: scale so the largest nonzero magnitude falls in [2^30, 2^31)
  logic [30:0] tms_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        tms_q[i] <= rsh_q ? 31'(tm4_q[i] >> 1) : 31'(tm4_q[i] << lsh_q);
      end
    end
  end

  // Stage 6: squares
  logic [61:0] sq_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq_q[i] <= 62'(tms_q[i]) * 62'(tms_q[i]);
    end
  end

  // Stage 7: sum of squares
  logic [63:0] ssum_q;

  always_ff @(posedge clk_i) begin
    if (en) ssum_q <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
  end

  // Length, stages 8 to 39
  logic [SQRT_RW-1:0] len;

  vtu_sqrt #(.RW(SQRT_RW)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .s_i    (ssum_q),
    .root_o (len)
  );

  logic [92:0] tms_d;

  vtu_dly #(.W(93), .N(TM_DLY)) u_tm_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({tms_q[2], tms_q[1], tms_q[0]}),
    .q_o   (tms_d)
  );

  // Stage 40: rounded dividend
  logic [NDIV_DW-1:0] ndvd_q [3];
  logic [NDIV_VW-1:0] nlen_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nlen_q <= len;
      for (int i = 0; i < 3; i++) begin
        ndvd_q[i] <= (NDIV_DW'(tms_d[31*i +: 31]) << 14) + NDIV_DW'(len >> 1);
      end
    end
  end

  // Normal division, stages 41 to 56
  logic [NDIV_QW-1:0] nquo [3];
  logic               novf [3];

  for (genvar i = 0; i < 3; i++) begin : g_ndiv
    vtu_div #(.DW(NDIV_DW), .VW(NDIV_VW), .QW(NDIV_QW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .dvd_i (ndvd_q[i]),
      .dvs_i (nlen_q),
      .quo_o (nquo[i]),
      .ovf_o (novf[i])
    );
  end

  nrm_flag_t nflag_d;

  vtu_dly #(.W($bits(nrm_flag_t)), .N(NFLAG_DLY)) u_nflag_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (nflag_q),
    .q_o   (nflag_d)
  );

  // Position division, stages 4 to 37
  logic [PDIV_QW-1:0] pquo [3];
  logic               povf [3];

  for (genvar i = 0; i < 3; i++) begin : g_pdiv
    vtu_div #(.DW(PDIV_DW), .VW(PDIV_VW), .QW(PDIV_QW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .dvd_i ({pmag_q[i], 16'd0}),
      .dvs_i (pmag_q[3]),
      .quo_o (pquo[i]),
      .ovf_o (povf[i])
    );
  end

  pos_flag_t pflag_d;

  vtu_dly #(.W($bits(pos_flag_t)), .N(PFLAG_DLY)) u_pflag_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (pflag_q),
    .q_o   (pflag_d)
  );

  // Stage 38: saturate and sign the position
  pos_res_t penc_q, penc_d;

  always_ff @(posedge clk_i) begin
    if (en) begin
      penc_q.wz <= pflag_d.wz;
      for (int i = 0; i < 3; i++) begin
        penc_q.val[i] <= enc_pos(pflag_d.wz, pflag_d.qz[i], pflag_d.qneg[i],
                                 pflag_d.neg[i], povf[i], pquo[i]);
      end
    end
  end

  vtu_dly #(.W($bits(pos_res_t)), .N(PENC_DLY)) u_penc_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (penc_q),
    .q_o   (penc_d)
  );

  // Stage 57: output register
  logic [15:0] nres [3];
  logic        nquo_bad;

  always_comb begin
    nquo_bad = novf[0] | novf[1] | novf[2];
    for (int i = 0; i < 3; i++) begin
      if (nflag_d.nz || nquo_bad) nres[i] = '0;
      else if (nflag_d.tneg[i]) nres[i] = 16'(17'd0 - 17'(nquo[i]));
      else nres[i] = 16'(nquo[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= {nres[2], nres[1], nres[0],
                       penc_d.val[2], penc_d.val[1], penc_d.val[0]};
      m_axis_tuser <= {nflag_d.nz, penc_d.wz};
    end
  end

  // Checks
  property p_nz_clears;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[143:96] == '0;
  endproperty
  a_nz_clears: assert property (p_nz_clears) else $error("zero normal not cleared");

  property p_unit_range;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |-> ($signed(m_axis_tdata[111:96]) <= 16'sd16384)
                     && ($signed(m_axis_tdata[111:96]) >= -16'sd16384);
  endproperty
  a_unit_range: assert property (p_unit_range) else $error("normal above unit length");

  property p_wz_sat;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && m_axis_tuser[0] |->
        (m_axis_tdata[31:0] == 32'h0) || (m_axis_tdata[31:0] == 32'h7FFF_FFFF)
        || (m_axis_tdata[31:0] == 32'h8000_0000);
  endproperty
  a_wz_sat: assert property (p_wz_sat) else $error("w zero result not saturated");

  property p_stall_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      !en |=> $stable(vld_q);
  endproperty
  a_stall_hold: assert property (p_stall_hold) else $error("pipeline moved in stall");

endmodule
